/* hw/rtl/shd_pkg.sv */
// Shared constants, types and state codes for the hint section decoder.
package shd_pkg;

    localparam int HINT_CAPACITY = 55;
    localparam int POLY_COUNT    = 6;
    localparam int SECTION_LEN   = HINT_CAPACITY + POLY_COUNT;

    // byte counter over one section
    localparam int CNT_W = $clog2(SECTION_LEN);
    // walk index, able to hold HINT_CAPACITY itself
    localparam int JW = $clog2(HINT_CAPACITY + 1);
    // index into the end-count registers
    localparam int PW = (POLY_COUNT > 1) ? $clog2(POLY_COUNT) : 1;
    // count of end counts at or below a position
    localparam int CW = $clog2(POLY_COUNT + 1);
    // two banks of index bytes, bank bit on top
    localparam int MEM_AW    = JW + 1;
    localparam int MEM_DEPTH = 1 << MEM_AW;

    localparam int BYTE_W  = 8;
    localparam int POLY_W  = 3;
    localparam int COEFF_W = 8;

    typedef struct packed {
        logic bank;
        logic ends_bad;
    } token_t;

    typedef struct packed {
        logic          en;
        logic          bank;
        logic [JW-1:0] idx;
    } rd_req_t;

    typedef struct packed {
        logic [POLY_W-1:0]  poly_index;
        logic [COEFF_W-1:0] coeff_index;
        logic               is_hint;
        logic               bad_encoding;
        logic               last_result;
    } result_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CHECK,
        BK_EMIT,
        BK_MARK,
        BK_FAIL
    } back_state_t;

endpackage

/* hw/rtl/sig_hint_decoder_core.sv */
// Hint section decoder top level: byte loader, section queue, checker/emitter, result queue.
// Bytes load one per cycle, while the section queue is not full, into one of two banks,
// HINT_CAPACITY + POLY_COUNT per section. From the last byte the checker walks the whole
// index area of the bank, then emits one result per hint and a done marker, stalled only
// by a full result queue; bad end counts skip the walk and give a single bad-section result.
// Reset clears control state, not the store.
module sig_hint_decoder_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [shd_pkg::BYTE_W-1:0]    section_byte,
    output logic                          empty,
    input  logic                          pop,
    output logic [shd_pkg::POLY_W-1:0]    poly_index,
    output logic [shd_pkg::COEFF_W-1:0]   coeff_index,
    output logic                          is_hint,
    output logic                          bad_encoding,
    output logic                          last_result
);

    logic                       accept;
    logic                       tok_push;
    shd_pkg::token_t            tok_data;
    shd_pkg::token_t            tok_head;
    logic                       tok_nonempty;
    logic                       tok_pop;
    shd_pkg::rd_req_t           rd_req;
    logic [shd_pkg::BYTE_W-1:0] rd_data;
    logic [shd_pkg::POLY_COUNT-1:0][shd_pkg::BYTE_W-1:0] ends;
    logic                       res_push;
    shd_pkg::result_t           res_data;
    logic                       res_full;
    shd_pkg::result_t           res_head;

    assign accept = push && !full;

    shd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .section_byte (section_byte),
        .tok_push     (tok_push),
        .tok_data     (tok_data),
        .rd_req       (rd_req),
        .rd_data      (rd_data),
        .ends         (ends)
    );

    shd_token_queue u_token_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (tok_push),
        .push_data (tok_data),
        .pop       (tok_pop),
        .head      (tok_head),
        .nonempty  (tok_nonempty),
        .full      (full)
    );

    shd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .tok_head     (tok_head),
        .tok_nonempty (tok_nonempty),
        .tok_pop      (tok_pop),
        .rd_req       (rd_req),
        .rd_data      (rd_data),
        .ends         (ends),
        .res_push     (res_push),
        .res_data     (res_data),
        .res_full     (res_full)
    );

    shd_result_queue u_result_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_data),
        .pop       (pop && !empty),
        .head      (res_head),
        .empty     (empty),
        .full      (res_full)
    );

    assign poly_index   = res_head.poly_index;
    assign coeff_index  = res_head.coeff_index;
    assign is_hint      = res_head.is_hint;
    assign bad_encoding = res_head.bad_encoding;
    assign last_result  = res_head.last_result;

endmodule

/* hw/rtl/shd_front.sv */
// Front end: loads section bytes into a two-bank store and checks the end counts.
module shd_front (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       accept,
    input  logic [shd_pkg::BYTE_W-1:0]                 section_byte,
    output logic                                       tok_push,
    output shd_pkg::token_t                            tok_data,
    input  shd_pkg::rd_req_t                           rd_req,
    output logic [shd_pkg::BYTE_W-1:0]                 rd_data,
    output logic [shd_pkg::POLY_COUNT-1:0][shd_pkg::BYTE_W-1:0] ends
);

    logic [shd_pkg::BYTE_W-1:0] mem [shd_pkg::MEM_DEPTH];
    logic [shd_pkg::BYTE_W-1:0] ends_reg [2][shd_pkg::POLY_COUNT];

    logic [shd_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                       bank_reg, bank_next;
    logic [shd_pkg::BYTE_W-1:0] prev_end_reg, prev_end_next;
    logic                       bad_reg, bad_next;

    logic [shd_pkg::CNT_W-1:0]  end_off;
    logic                       is_index;
    logic                       is_last;
    logic                       end_bad;

    assign end_off  = cnt_reg - shd_pkg::CNT_W'(shd_pkg::HINT_CAPACITY);
    assign is_index = cnt_reg < shd_pkg::CNT_W'(shd_pkg::HINT_CAPACITY);
    assign is_last  = cnt_reg == shd_pkg::CNT_W'(shd_pkg::SECTION_LEN - 1);
    assign end_bad  = (section_byte > shd_pkg::BYTE_W'(shd_pkg::HINT_CAPACITY))
                   || (section_byte < prev_end_reg);

    always_comb
    begin
        cnt_next      = cnt_reg;
        bank_next     = bank_reg;
        prev_end_next = prev_end_reg;
        bad_next      = bad_reg;
        tok_push      = 1'b0;
        tok_data      = '{bank: bank_reg, ends_bad: bad_reg};
        if (accept)
        begin
            if (!is_index)
            begin
                prev_end_next = section_byte;
                bad_next      = bad_reg | end_bad;
            end
            if (is_last)
            begin
                tok_push      = 1'b1;
                tok_data      = '{bank: bank_reg, ends_bad: bad_reg | end_bad};
                cnt_next      = '0;
                bank_next     = ~bank_reg;
                prev_end_next = '0;
                bad_next      = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            bank_reg     <= 1'b0;
            prev_end_reg <= '0;
            bad_reg      <= 1'b0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            bank_reg     <= bank_next;
            prev_end_reg <= prev_end_next;
            bad_reg      <= bad_next;
        end
    end

    // store write side
    always_ff @(posedge clk)
    begin
        if (accept && is_index)
            mem[{bank_reg, cnt_reg[shd_pkg::JW-1:0]}] <= section_byte;
        if (accept && !is_index)
            ends_reg[bank_reg][end_off[shd_pkg::PW-1:0]] <= section_byte;
    end

    // registered read port; data holds while en is low
    always_ff @(posedge clk)
    begin
        if (rd_req.en)
            rd_data <= mem[{rd_req.bank, rd_req.idx}];
    end

    always_comb
    begin
        for (int p = 0; p < shd_pkg::POLY_COUNT; p++)
            ends[p] = ends_reg[rd_req.bank][p];
    end

endmodule

/* hw/rtl/shd_token_queue.sv */
// Two-entry queue of loaded sections between the front and back ends.
module shd_token_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  shd_pkg::token_t push_data,
    input  logic            pop,
    output shd_pkg::token_t head,
    output logic            nonempty,
    output logic            full
);

    shd_pkg::token_t slot_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;

    assign head     = slot_reg[rd_ptr_reg];
    assign nonempty = count_reg != 2'd0;
    assign full     = count_reg == 2'd2;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = ~wr_ptr_reg;
        if (pop)
            rd_ptr_next = ~rd_ptr_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

/* hw/rtl/shd_back.sv */
// Back end: walks a loaded section to validate it, then emits its hints.
module shd_back (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  shd_pkg::token_t                            tok_head,
    input  logic                                       tok_nonempty,
    output logic                                       tok_pop,
    output shd_pkg::rd_req_t                           rd_req,
    input  logic [shd_pkg::BYTE_W-1:0]                 rd_data,
    input  logic [shd_pkg::POLY_COUNT-1:0][shd_pkg::BYTE_W-1:0] ends,
    output logic                                       res_push,
    output shd_pkg::result_t                           res_data,
    input  logic                                       res_full
);

    shd_pkg::back_state_t       state_reg, state_next;
    logic                       bank_reg, bank_next;
    logic [shd_pkg::JW-1:0]     j_reg, j_next;
    logic [shd_pkg::JW-1:0]     dj_reg, dj_next;
    logic                       dv_reg, dv_next;
    logic [shd_pkg::BYTE_W-1:0] prev_reg, prev_next;
    logic                       bad_reg, bad_next;

    logic [shd_pkg::BYTE_W-1:0] final_end;
    logic [shd_pkg::BYTE_W-1:0] limit;
    logic [shd_pkg::BYTE_W-1:0] dj_ext;
    logic                       walking;
    logic                       issue_more;
    logic                       stall;
    logic                       boundary;
    logic [shd_pkg::CW-1:0]     poly_cnt;

    assign final_end  = ends[shd_pkg::POLY_COUNT-1];
    assign walking    = (state_reg == shd_pkg::BK_CHECK) || (state_reg == shd_pkg::BK_EMIT);
    assign limit      = (state_reg == shd_pkg::BK_CHECK)
                      ? shd_pkg::BYTE_W'(shd_pkg::HINT_CAPACITY) : final_end;
    assign issue_more = shd_pkg::BYTE_W'(j_reg) < limit;
    assign stall      = (state_reg == shd_pkg::BK_EMIT) && dv_reg && res_full;
    assign dj_ext     = shd_pkg::BYTE_W'(dj_reg);

    assign rd_req.en   = !stall;
    assign rd_req.bank = bank_reg;
    assign rd_req.idx  = j_reg;

    // position starts a polynomial; polynomial of a position = ends at or below it
    always_comb
    begin
        boundary = (dj_reg == '0);
        poly_cnt = '0;
        for (int p = 0; p < shd_pkg::POLY_COUNT; p++)
        begin
            if (ends[p] == dj_ext)
                boundary = 1'b1;
            if (ends[p] <= dj_ext)
                poly_cnt = poly_cnt + 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        bank_next  = bank_reg;
        j_next     = j_reg;
        dj_next    = dj_reg;
        dv_next    = dv_reg;
        prev_next  = prev_reg;
        bad_next   = bad_reg;
        tok_pop    = 1'b0;
        res_push   = 1'b0;
        res_data   = '{poly_index: '0, coeff_index: '0, is_hint: 1'b0,
                       bad_encoding: 1'b0, last_result: 1'b1};

        if (walking && !stall)
        begin
            if (issue_more)
            begin
                j_next  = j_reg + 1'b1;
                dj_next = j_reg;
                dv_next = 1'b1;
            end
            else
            begin
                dv_next = 1'b0;
            end
        end

        unique case (state_reg)
            shd_pkg::BK_IDLE:
            begin
                if (tok_nonempty)
                begin
                    bank_next = tok_head.bank;
                    j_next    = '0;
                    dv_next   = 1'b0;
                    bad_next  = 1'b0;
                    prev_next = '0;
                    state_next = tok_head.ends_bad ? shd_pkg::BK_FAIL : shd_pkg::BK_CHECK;
                end
            end
            shd_pkg::BK_CHECK:
            begin
                if (dv_reg)
                begin
                    prev_next = rd_data;
                    if (dj_ext < final_end)
                    begin
                        if (!boundary && (rd_data <= prev_reg))
                            bad_next = 1'b1;
                    end
                    else if (rd_data != '0)
                    begin
                        bad_next = 1'b1;
                    end
                end
                else if (!issue_more)
                begin
                    j_next     = '0;
                    state_next = bad_reg ? shd_pkg::BK_FAIL : shd_pkg::BK_EMIT;
                end
            end
            shd_pkg::BK_EMIT:
            begin
                if (dv_reg)
                begin
                    res_push = !res_full;
                    res_data = '{poly_index: shd_pkg::POLY_W'(poly_cnt),
                                 coeff_index: rd_data, is_hint: 1'b1,
                                 bad_encoding: 1'b0, last_result: 1'b0};
                end
                else if (!issue_more)
                begin
                    state_next = shd_pkg::BK_MARK;
                end
            end
            shd_pkg::BK_MARK:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    tok_pop    = 1'b1;
                    state_next = shd_pkg::BK_IDLE;
                end
            end
            shd_pkg::BK_FAIL:
            begin
                res_data.bad_encoding = 1'b1;
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    tok_pop    = 1'b1;
                    state_next = shd_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = shd_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= shd_pkg::BK_IDLE;
            dv_reg    <= 1'b0;
            bad_reg   <= 1'b0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            dv_reg    <= dv_next;
            bad_reg   <= bad_next;
            j_reg     <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bank_reg <= bank_next;
        dj_reg   <= dj_next;
        prev_reg <= prev_next;
    end

endmodule

/* hw/rtl/shd_result_queue.sv */
// Two-entry result queue that drives the output ports.
module shd_result_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  shd_pkg::result_t push_data,
    input  logic             pop,
    output shd_pkg::result_t head,
    output logic             empty,
    output logic             full
);

    shd_pkg::result_t slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    assign head  = slot_reg[rd_ptr_reg];
    assign empty = count_reg == 2'd0;
    assign full  = count_reg == 2'd2;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = ~wr_ptr_reg;
        if (pop)
            rd_ptr_next = ~rd_ptr_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

/* verif/sig_hint_decoder_core_tb.sv */
// Self-checking testbench for sig_hint_decoder_core: directed and random hint sections.
`timescale 1ns / 1ps

module sig_hint_decoder_core_tb;

    typedef enum logic [1:0] {
        FILL_LOW,
        FILL_HIGH,
        FILL_RAND
    } fill_t;

    typedef enum logic [2:0] {
        FLAW_NONE,
        FLAW_ORDER,
        FLAW_TRAIL,
        FLAW_OVER,
        FLAW_FALL,
        FLAW_NOISE
    } flaw_t;

    typedef enum logic [1:0] {
        OUT_PREDICT,
        OUT_MARK_ONLY,
        OUT_ERROR
    } outcome_t;

    typedef struct packed {
        logic [0:shd_pkg::POLY_COUNT-1][shd_pkg::BYTE_W-1:0] ends;
        fill_t                                               fill;
        flaw_t                                               flaw;
        outcome_t                                            outcome;
    } section_row_t;

    localparam shd_pkg::result_t DONE_MARK   =
        shd_pkg::result_t'{3'd0, 8'd0, 1'b0, 1'b0, 1'b1};
    localparam shd_pkg::result_t BAD_SECTION =
        shd_pkg::result_t'{3'd0, 8'd0, 1'b0, 1'b1, 1'b1};

    localparam int RAND_SECTIONS = 2;
    localparam int PLAN_LEN = 7;
    localparam section_row_t PLAN [PLAN_LEN] = '{
        // empty section right after reset: only the done marker
        '{{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, FILL_RAND, FLAW_NONE, OUT_MARK_ONLY},
        // every hint in the first polynomial, coefficients from zero up
        '{{8'd55, 8'd55, 8'd55, 8'd55, 8'd55, 8'd55}, FILL_LOW, FLAW_NONE, OUT_PREDICT},
        // one hint per polynomial, same coefficient across boundaries is legal
        '{{8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6}, FILL_HIGH, FLAW_NONE, OUT_PREDICT},
        // end count past capacity
        '{{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd56}, FILL_RAND, FLAW_NONE, OUT_ERROR},
        // end count going down
        '{{8'd10, 8'd5, 8'd20, 8'd30, 8'd40, 8'd50}, FILL_RAND, FLAW_NONE, OUT_ERROR},
        // coefficients not strictly rising
        '{{8'd5, 8'd12, 8'd30, 8'd31, 8'd40, 8'd50}, FILL_HIGH, FLAW_ORDER, OUT_ERROR},
        // nonzero byte in the unused index area
        '{{8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10}, FILL_RAND, FLAW_TRAIL, OUT_ERROR}
    };

    logic                          clk;
    logic                          rst_n;
    logic                          push;
    logic                          full;
    logic [shd_pkg::BYTE_W-1:0]    section_byte;
    logic                          empty;
    logic                          pop;
    logic [shd_pkg::POLY_W-1:0]    poly_index;
    logic [shd_pkg::COEFF_W-1:0]   coeff_index;
    logic                          is_hint;
    logic                          bad_encoding;
    logic                          last_result;

    // predictor state
    logic [shd_pkg::BYTE_W-1:0] held [shd_pkg::SECTION_LEN];
    int                         held_count = 0;
    shd_pkg::result_t           decoded_now [$];

    shd_pkg::result_t           awaited_results [$];
    logic [shd_pkg::BYTE_W-1:0] section_bytes [shd_pkg::SECTION_LEN];

    bit sender_calm   = 1'b0;
    bit receiver_calm = 1'b0;
    int fail_count    = 0;
    int bytes_sent    = 0;
    int sections_sent = 0;
    int hints_seen    = 0;
    int marks_seen    = 0;
    int rejects_seen  = 0;

    sig_hint_decoder_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .section_byte (section_byte),
        .empty        (empty),
        .pop          (pop),
        .poly_index   (poly_index),
        .coeff_index  (coeff_index),
        .is_hint      (is_hint),
        .bad_encoding (bad_encoding),
        .last_result  (last_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("sig_hint_decoder_core_tb: done, errors");
        $finish;
    end

    function automatic string show(input shd_pkg::result_t r);
        return $sformatf("poly=%0d coeff=%0d hint=%0b bad=%0b last=%0b",
                         r.poly_index, r.coeff_index, r.is_hint, r.bad_encoding,
                         r.last_result);
    endfunction

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t ERROR %s", $time, what);
    endtask

    // Takes one accepted byte; on the last byte of a section leaves its results
    // in decoded_now.
    task automatic decode_byte(input logic [shd_pkg::BYTE_W-1:0] b);
        int p;
        int j;
        int prev;
        int last_end;
        bit ok;
        decoded_now.delete();
        held[held_count] = b;
        held_count++;
        if (held_count < shd_pkg::SECTION_LEN)
            return;
        held_count = 0;
        ok = 1'b1;
        prev = 0;
        for (p = 0; p < shd_pkg::POLY_COUNT && ok; p++)
        begin
            last_end = int'(held[shd_pkg::HINT_CAPACITY + p]);
            if (last_end < prev || last_end > shd_pkg::HINT_CAPACITY)
                ok = 1'b0;
            else
            begin
                for (j = prev + 1; j < last_end; j++)
                    if (held[j] <= held[j - 1])
                        ok = 1'b0;
                prev = last_end;
            end
        end
        if (ok)
            for (j = prev; j < shd_pkg::HINT_CAPACITY; j++)
                if (held[j] != 0)
                    ok = 1'b0;
        if (!ok)
        begin
            decoded_now.push_back(BAD_SECTION);
            return;
        end
        prev = 0;
        for (p = 0; p < shd_pkg::POLY_COUNT; p++)
        begin
            last_end = int'(held[shd_pkg::HINT_CAPACITY + p]);
            for (j = prev; j < last_end; j++)
                decoded_now.push_back(shd_pkg::result_t'{shd_pkg::POLY_W'(p), held[j],
                                                         1'b1, 1'b0, 1'b0});
            prev = last_end;
        end
        decoded_now.push_back(DONE_MARK);
    endtask

    task automatic build_section(input section_row_t row);
        int  lo;
        int  hi;
        int  n;
        int  cur;
        int  maxv;
        int  val;
        int  k;
        int  p;
        int  j;
        int  cand [$];
        bit  is_start [shd_pkg::HINT_CAPACITY];
        for (j = 0; j < shd_pkg::SECTION_LEN; j++)
            section_bytes[j] = '0;
        for (j = 0; j < shd_pkg::HINT_CAPACITY; j++)
            is_start[j] = 1'b0;
        lo = 0;
        for (p = 0; p < shd_pkg::POLY_COUNT; p++)
        begin
            // clamp so that bad end counts still give a sane index area
            hi = int'(row.ends[p]);
            if (hi > shd_pkg::HINT_CAPACITY)
                hi = shd_pkg::HINT_CAPACITY;
            if (hi < lo)
                hi = lo;
            n = hi - lo;
            cur = 0;
            if (lo < shd_pkg::HINT_CAPACITY)
                is_start[lo] = 1'b1;
            for (k = 0; k < n; k++)
            begin
                maxv = 255 - (n - 1 - k);
                case (row.fill)
                    FILL_LOW:  val = cur;
                    FILL_HIGH: val = maxv;
                    default:   val = cur + $urandom_range(0, (maxv - cur) / (n - k));
                endcase
                section_bytes[lo + k] = shd_pkg::BYTE_W'(val);
                cur = val + 1;
            end
            section_bytes[shd_pkg::HINT_CAPACITY + p] = row.ends[p];
            lo = hi;
        end
        case (row.flaw)
            FLAW_ORDER:
            begin
                for (j = 1; j < lo; j++)
                    if (!is_start[j])
                        cand.push_back(j);
                if (cand.size() != 0)
                begin
                    j = cand[$urandom_range(0, cand.size() - 1)];
                    section_bytes[j] =
                        shd_pkg::BYTE_W'($urandom_range(0, section_bytes[j - 1]));
                end
            end
            FLAW_TRAIL:
                if (lo < shd_pkg::HINT_CAPACITY)
                    section_bytes[$urandom_range(lo, shd_pkg::HINT_CAPACITY - 1)] =
                        shd_pkg::BYTE_W'($urandom_range(1, 255));
            FLAW_OVER:
                section_bytes[shd_pkg::HINT_CAPACITY
                              + $urandom_range(0, shd_pkg::POLY_COUNT - 1)] =
                    shd_pkg::BYTE_W'($urandom_range(shd_pkg::HINT_CAPACITY + 1, 255));
            FLAW_FALL:
            begin
                for (p = 1; p < shd_pkg::POLY_COUNT; p++)
                    if (section_bytes[shd_pkg::HINT_CAPACITY + p - 1] != 0)
                        cand.push_back(p);
                if (cand.size() != 0)
                begin
                    p = cand[$urandom_range(0, cand.size() - 1)];
                    section_bytes[shd_pkg::HINT_CAPACITY + p] = shd_pkg::BYTE_W'(
                        $urandom_range(0, section_bytes[shd_pkg::HINT_CAPACITY + p - 1] - 1));
                end
            end
            FLAW_NOISE:
                for (j = 0; j < shd_pkg::SECTION_LEN; j++)
                    section_bytes[j] = shd_pkg::BYTE_W'($urandom_range(0, 255));
            default:
                ;
        endcase
    endtask

    task automatic send_byte(input logic [shd_pkg::BYTE_W-1:0] b);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 4);
        @(negedge clk);
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push         <= 1'b1;
        section_byte <= b;
        do
            @(posedge clk);
        while (full !== 1'b0);
        decode_byte(b);
        bytes_sent++;
    endtask

    task automatic send_section(input section_row_t row);
        int j;
        build_section(row);
        sender_calm   = ($urandom_range(0, 3) == 0);
        receiver_calm = ($urandom_range(0, 3) == 0);
        for (j = 0; j < shd_pkg::SECTION_LEN; j++)
            send_byte(section_bytes[j]);
        case (row.outcome)
            OUT_MARK_ONLY: awaited_results.push_back(DONE_MARK);
            OUT_ERROR:     awaited_results.push_back(BAD_SECTION);
            default:
                foreach (decoded_now[k])
                    awaited_results.push_back(decoded_now[k]);
        endcase
        sections_sent++;
    endtask

    // hold off the sender until every predicted result has come out
    task automatic wait_drained();
        @(negedge clk);
        push <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : result_check
        shd_pkg::result_t got;
        shd_pkg::result_t want;
        int               stall;
        pop   = 1'b0;
        stall = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                got = shd_pkg::result_t'{poly_index, coeff_index, is_hint, bad_encoding,
                                         last_result};
                if (got.is_hint)
                    hints_seen++;
                else if (got.bad_encoding)
                    rejects_seen++;
                else
                    marks_seen++;
                if (awaited_results.size() == 0)
                    note_failure($sformatf("result with nothing expected: %s", show(got)));
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.poly_index !== want.poly_index
                        || got.coeff_index !== want.coeff_index
                        || got.is_hint !== want.is_hint
                        || got.bad_encoding !== want.bad_encoding
                        || got.last_result !== want.last_result)
                        note_failure($sformatf("expected %s, got %s", show(want), show(got)));
                end
                stall = receiver_calm ? 0 : $urandom_range(0, 4);
            end
            @(negedge clk);
            if (stall != 0)
            begin
                pop <= 1'b0;
                stall--;
            end
            else
                pop <= 1'b1;
        end
    end

    initial
    begin : stimulus
        section_row_t row;
        int           s;
        int           p;
        int           k;
        int           m;
        int           total;
        int           tmp;
        int           cuts [shd_pkg::POLY_COUNT];
        rst_n        = 1'b0;
        push         = 1'b0;
        section_byte = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (s = 0; s < PLAN_LEN; s++)
            send_section(PLAN[s]);
        wait_drained();

        for (s = 0; s < RAND_SECTIONS; s++)
        begin
            total = ($urandom_range(0, 7) == 0) ? shd_pkg::HINT_CAPACITY
                                                : $urandom_range(0, shd_pkg::HINT_CAPACITY);
            for (p = 0; p < shd_pkg::POLY_COUNT; p++)
                cuts[p] = $urandom_range(0, total);
            for (p = 1; p < shd_pkg::POLY_COUNT; p++)
            begin
                tmp = cuts[p];
                k = p;
                while (k > 0 && cuts[k - 1] > tmp)
                begin
                    cuts[k] = cuts[k - 1];
                    k--;
                end
                cuts[k] = tmp;
            end
            for (p = 0; p < shd_pkg::POLY_COUNT; p++)
                row.ends[p] = shd_pkg::BYTE_W'((p == shd_pkg::POLY_COUNT - 1) ? total
                                                                             : cuts[p]);
            k = $urandom_range(0, 9);
            row.fill = (k == 0) ? FILL_LOW : (k == 1) ? FILL_HIGH : FILL_RAND;
            // mostly well-formed sections, the rest damaged in one way
            m = $urandom_range(0, 11);
            row.flaw = (m < 7)   ? FLAW_NONE  :
                       (m == 7)  ? FLAW_ORDER :
                       (m == 8)  ? FLAW_TRAIL :
                       (m == 9)  ? FLAW_OVER  :
                       (m == 10) ? FLAW_FALL  : FLAW_NOISE;
            row.outcome = OUT_PREDICT;
            send_section(row);
            if ($urandom_range(0, 3) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (4 * shd_pkg::SECTION_LEN) @(posedge clk);
        $display("covered %0d sections in %0d bytes, with or without stalls on each side",
                 sections_sent, bytes_sent);
        $display("results seen: %0d hints, %0d done markers, %0d rejected sections",
                 hints_seen, marks_seen, rejects_seen);
        if (fail_count == 0)
            $display("sig_hint_decoder_core_tb: done, clean");
        else
            $display("sig_hint_decoder_core_tb: done, errors");
        $finish;
    end

endmodule
